>>> design/fir_lp_pkg.sv
// ----------------------------------------------------------------------------
// fir_lp_pkg
// Shared types and constants for the low-pass FIR: the Q1.17 half table of
// the symmetric coefficient set, table geometry, and output limits.
// ----------------------------------------------------------------------------
`default_nettype none

package fir_lp_pkg;

   // Coefficient table geometry (full table is mirrored about the center)
   localparam int ROM_TAPS = 101;
   localparam int ROM_HALF = 51;
   localparam int ROM_FRAC = 17;

   // Output saturation limits
   localparam int OUT_MAX = 32767;
   localparam int OUT_MIN = -32768;

   // Sample word
   typedef logic signed [15:0] sample_type;

   // Half table entry, unsigned Q1.17 magnitude
   typedef logic [11:0] rom_entry_type;

   // First half and center of the symmetric table, Q1.17
   localparam rom_entry_type HALF_ROM [ROM_HALF] = '{
      12'd187,  12'd190,  12'd196,  12'd207,  12'd222,
      12'd242,  12'd265,  12'd293,  12'd324,  12'd360,
      12'd399,  12'd441,  12'd487,  12'd537,  12'd589,
      12'd644,  12'd702,  12'd763,  12'd825,  12'd890,
      12'd956,  12'd1024, 12'd1093, 12'd1163, 12'd1233,
      12'd1304, 12'd1375, 12'd1445, 12'd1516, 12'd1585,
      12'd1653, 12'd1720, 12'd1786, 12'd1849, 12'd1911,
      12'd1970, 12'd2027, 12'd2080, 12'd2131, 12'd2178,
      12'd2222, 12'd2262, 12'd2299, 12'd2331, 12'd2360,
      12'd2384, 12'd2404, 12'd2420, 12'd2431, 12'd2438,
      12'd2440
   };

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RUN   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_SAT   = 5'b10000
   } state_type;

endpackage

`default_nettype wire

>>> design/fir_lowpass_101_tap.sv
// ----------------------------------------------------------------------------
// fir_lowpass_101_tap
// Direct-form low-pass FIR with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Each accepted sample word is written into a circular delay line held in a
// single-port-write, registered-read memory, then convolved newest-to-oldest
// with a fixed symmetric coefficient set, one tap per cycle through one
// multiplier and one accumulator. A word goes from acceptance to result
// in order: delay-line reads into the MAC, one per tap, a drain of the
// two-stage MAC pipeline, truncation toward zero, and saturation into the
// output register. The next word can be taken once the result is
// registered, so a new word is not taken before the last one has been
// through all of these steps. The input side is not ready while a word is
// in the MAC; a finished result waits in the output register, so the next
// sample word is taken even while the previous result is still pending. The
// saturation step holds while the output register still has an untaken
// result. The delay line reads as zero after reset through per-slot valid
// bits that reset clears at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_lowpass_101_tap
   import fir_lp_pkg::*;
#(
   parameter int TAP_COUNT  = 101,
   parameter int COEF_WIDTH = 18
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [15:0] filtered_out
);

   localparam int PTR_W  = $clog2(TAP_COUNT);
   localparam int FRAC   = COEF_WIDTH - 1;
   localparam int PROD_W = 16 + COEF_WIDTH;
   localparam int ACC_W  = PROD_W + PTR_W;
   localparam int SH_W   = ACC_W - FRAC;
   localparam int UP_SH  = (FRAC >= ROM_FRAC) ? (FRAC - ROM_FRAC) : 0;
   localparam int DN_SH  = (FRAC < ROM_FRAC) ? (ROM_FRAC - FRAC) : 0;
   localparam int DN_RND = (DN_SH > 0) ? (1 << (DN_SH - 1)) : 0;

   localparam logic [PTR_W-1:0]        LAST_TAP   = PTR_W'(TAP_COUNT - 1);
   localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'sd1 <<< FRAC) - 64'sd1);
   localparam logic signed [SH_W-1:0]  SAT_HI     = SH_W'(OUT_MAX);
   localparam logic signed [SH_W-1:0]  SAT_LO     = SH_W'(OUT_MIN);

   // Coefficient for one tap, scaled from Q1.17 to COEF_WIDTH-1 fraction bits
   function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [PTR_W-1:0] tap);
      int          t;
      int          idx;
      logic [31:0] q;
      t = int'(tap);
      if (t >= ROM_TAPS) begin
         return '0;
      end
      idx = (t < ROM_HALF) ? t : (ROM_TAPS - 1 - t);
      q   = 32'(HALF_ROM[idx[5:0]]);
      if (FRAC >= ROM_FRAC) begin
         q = q << UP_SH;
      end else begin
         q = (q + 32'(DN_RND)) >> DN_SH;
      end
      return COEF_WIDTH'(q);
   endfunction

   state_type                 state_ff, state_in;
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]          tap_ff, tap_in;
   logic [TAP_COUNT-1:0]      slot_valid_ff;
   sample_type                line_mem [TAP_COUNT];
   sample_type                rd_data_ff;
   logic                      rd_valid_ff;
   logic signed [COEF_WIDTH-1:0] coef_ff;
   logic                      s1_v_ff, s1_v_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      s2_v_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   acc_biased;
   logic signed [SH_W-1:0]    shifted_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]               rsp_data_ff, rsp_data_in;
   logic                      req_accept;
   logic                      out_free;
   sample_type                mac_sample;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Sequencer: issue taps, drain the MAC, truncate, saturate
   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      tap_in       = tap_ff;
      s1_v_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rd_ptr_in = wr_ptr_ff;
               wr_ptr_in = (wr_ptr_ff == LAST_TAP) ? '0 : wr_ptr_ff + 1'b1;
               tap_in    = '0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            s1_v_in   = 1'b1;
            rd_ptr_in = (rd_ptr_ff == '0) ? LAST_TAP : rd_ptr_ff - 1'b1;
            tap_in    = tap_ff + 1'b1;
            if (tap_ff == LAST_TAP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (shifted_ff > SAT_HI) begin
                  rsp_data_in = 16'(SAT_HI);
               end else if (shifted_ff < SAT_LO) begin
                  rsp_data_in = 16'(SAT_LO);
               end else begin
                  rsp_data_in = 16'(shifted_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Mask never-written slots to zero and accumulate each product
   assign mac_sample = rd_valid_ff ? rd_data_ff : '0;
   always_comb begin
      acc_in = acc_ff;
      if (req_accept) begin
         acc_in = '0;
      end else if (s2_v_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // Truncate toward zero: bias negative sums before the arithmetic shift
   assign acc_biased = acc_ff + (acc_ff[ACC_W-1] ? TRUNC_BIAS : '0);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         tap_ff        <= '0;
         slot_valid_ff <= '0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         tap_ff       <= tap_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s1_v_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            slot_valid_ff[wr_ptr_ff] <= 1'b1;
         end
      end
   end

   // Delay line memory: write on accept, registered read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         line_mem[wr_ptr_ff] <= sample_type'(req_tdata);
      end
      rd_data_ff <= line_mem[rd_ptr_ff];
   end

   // MAC datapath
   always_ff @(posedge clock) begin
      rd_valid_ff <= slot_valid_ff[rd_ptr_ff];
      coef_ff     <= coef_at(tap_ff);
      prod_ff     <= PROD_W'(mac_sample) * PROD_W'(coef_ff);
      acc_ff      <= acc_in;
      if (state_ff == ST_ROUND) begin
         shifted_ff <= acc_biased[ACC_W-1:FRAC];
      end
      rsp_data_ff <= rsp_data_in;
   end

   // An accepted word starts the tap sweep at tap zero
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_RUN) && (tap_ff == '0))
      else $error("accepted word did not start the tap sweep");

   // A new result only comes out of the saturation step
   a_result_from_sat: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SAT))
      else $error("result appeared outside the saturation step");

   // The MAC pipeline is empty whenever a new word can be taken
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_v_ff && !s2_v_ff))
      else $error("MAC pipeline busy while idle");

endmodule

`default_nettype wire
